/* rtl/core/seven_segment_frame_builder_assert.svh */
// Assertion macros shared by the frame builder checkers.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SEVEN_SEGMENT_FRAME_BUILDER_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SSFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SSFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ssfb_pkg.sv */
// Package for the seven-segment frame builder: command bytes, segment codes,
// word positions within one update and configuration register indexes.
// No dependencies.
package ssfb_pkg;

	// Display command bytes
	localparam logic [7:0] CMD_DATA  = 8'h40;
	localparam logic [7:0] CMD_ADDR  = 8'hC0;
	localparam logic [7:0] CMD_ON    = 8'h88;

	// Segment patterns, bits are [colon][g][f][e][d][c][b][a]
	localparam logic [7:0] SEG_E     = 8'h79;
	localparam logic [7:0] SEG_R     = 8'h50;
	localparam logic [7:0] SEG_COLON = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	// Error code that shows a blank last digit
	localparam logic [7:0] ERR_BLANK_CODE = 8'h10;

	// Configuration register indexes
	localparam logic CFG_BRIGHTNESS = 1'b0;
	localparam logic CFG_SHOW_ZEROS = 1'b1;

	// Word positions within one display update
	localparam logic [2:0] WORD_DATA_CMD = 3'd0;
	localparam logic [2:0] WORD_ADDR_CMD = 3'd1;
	localparam logic [2:0] WORD_DIGIT0   = 3'd2;
	localparam logic [2:0] WORD_DIGIT1   = 3'd3;
	localparam logic [2:0] WORD_DIGIT2   = 3'd4;
	localparam logic [2:0] WORD_DIGIT3   = 3'd5;
	localparam logic [2:0] WORD_ON_CMD   = 3'd6;

	// Decimal digit to segment pattern
	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] seg;
		unique case (digit)
			4'd0: seg = 8'h3f;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5b;
			4'd3: seg = 8'h4f;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6d;
			4'd6: seg = 8'h7d;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7f;
			4'd9: seg = 8'h6f;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

/* rtl/core/seven_segment_frame_builder.sv */
// Seven-segment frame builder: turns a number or error request into the
// seven framed command words of one display update. Depends on ssfb_pkg.
//
// Each accepted request produces seven output words, one per cycle when the
// output is not stalled, so the sustained request rate is set by the single
// output word port. A request passes a four-stage pipeline (input register,
// thousands split, hundreds split, digit/segment register), and its first
// word is offered once it reaches the digit/segment register. Up to three
// further requests are held in the pipeline while the current update drains.
// Write configuration only while no request is in flight: the blanking mode
// is read when the digits are built and the brightness when the final word
// goes out.
module seven_segment_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [15:0] number_value,
	input  logic       colon_on,
	input  logic [7:0] error_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       frame_start,
	output logic       frame_stop,
	output logic       last_byte
);
	import ssfb_pkg::*;

	// Configuration registers
	logic [2:0] brightness_q;
	logic       show_zeros_q;

	// Pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_s1, load_s2, load_s3, load_s4;
	logic out_fire, last_fire;
	logic [2:0] word_idx_q;

	// Stage 1 payload
	logic        func_s1, colon_s1;
	logic [15:0] num_s1;
	logic [7:0]  code_s1;

	// Stage 2 payload
	logic       func_s2, colon_s2, cblank_s2;
	logic [6:0] th_s2;
	logic [9:0] rem_s2;
	logic [3:0] cdig_s2;

	// Stage 3 payload
	logic       func_s3, colon_s3, cblank_s3;
	logic [3:0] d0_s3, d1_s3, cdig_s3;
	logic [6:0] r2_s3;

	// Stage 4 payload: the four digit words
	logic [7:0] dig0_s4, dig1_s4, dig2_s4, dig3_s4;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 3'd7;
			show_zeros_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BRIGHTNESS: brightness_q <= cfg_data;
				CFG_SHOW_ZEROS: show_zeros_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its contents move on
	assign out_fire  = valid_s4 && !out_stall;
	assign last_fire = out_fire && (word_idx_q == WORD_ON_CMD);
	assign load_s4   = !valid_s4 || last_fire;
	assign load_s3   = !valid_s3 || load_s4;
	assign load_s2   = !valid_s2 || load_s3;
	assign load_s1   = !valid_s1 || load_s2;
	assign in_stall  = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
			word_idx_q <= WORD_DATA_CMD;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
			if (last_fire) begin
				word_idx_q <= WORD_DATA_CMD;
			end else if (out_fire) begin
				word_idx_q <= word_idx_q + 3'd1;
			end
		end
	end

	// Stage 1: capture the request
	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1  <= func;
			num_s1   <= number_value;
			colon_s1 <= colon_on;
			code_s1  <= error_code;
		end
	end

	// Stage 2: split off thousands (n / 1000 by reciprocal), code mod 10
	logic [32:0] th_prod;
	logic [6:0]  th_w;
	logic [15:0] rem_w;
	logic [15:0] cq_prod;
	logic [4:0]  cq_w;
	logic [7:0]  cdig_w;

	always_comb begin
		th_prod = {17'd0, num_s1} * 33'd67109;
		th_w    = th_prod[32:26];
		rem_w   = num_s1 - ({9'd0, th_w} * 16'd1000);
		cq_prod = {8'd0, code_s1} * 16'd205;
		cq_w    = cq_prod[15:11];
		cdig_w  = code_s1 - ({3'd0, cq_w} * 8'd10);
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			func_s2   <= func_s1;
			colon_s2  <= colon_s1;
			th_s2     <= th_w;
			rem_s2    <= rem_w[9:0];
			cdig_s2   <= cdig_w[3:0];
			cblank_s2 <= (code_s1 == ERR_BLANK_CODE);
		end
	end

	// Stage 3: thousands digit (thousands count mod 10), hundreds digit and remainder
	logic [13:0] tq_prod;
	logic [2:0]  tq_w;
	logic [6:0]  d0_w;
	logic [19:0] h_prod;
	logic [3:0]  h_w;
	logic [9:0]  r2_w;

	always_comb begin
		tq_prod = {7'd0, th_s2} * 14'd205;
		tq_w    = tq_prod[13:11];
		d0_w    = th_s2 - ({4'd0, tq_w} * 7'd10);
		h_prod  = {10'd0, rem_s2} * 20'd656;
		h_w     = h_prod[19:16];
		r2_w    = rem_s2 - ({6'd0, h_w} * 10'd100);
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			func_s3   <= func_s2;
			colon_s3  <= colon_s2;
			cblank_s3 <= cblank_s2;
			cdig_s3   <= cdig_s2;
			d0_s3     <= d0_w[3:0];
			d1_s3     <= h_w;
			r2_s3     <= r2_w[6:0];
		end
	end

	// Stage 4: tens and units, blank leading zeros, map to segments or the error pattern
	logic [14:0] t_prod;
	logic [3:0]  t_w;
	logic [6:0]  u_w;
	logic        blank0, blank1, blank2;
	logic [7:0]  seg0_w, seg1_w, seg2_w, seg3_w;

	always_comb begin
		t_prod = {8'd0, r2_s3} * 15'd205;
		t_w    = t_prod[14:11];
		u_w    = r2_s3 - ({3'd0, t_w} * 7'd10);
		blank0 = !show_zeros_q && (d0_s3 == 4'd0);
		blank1 = blank0 && (d1_s3 == 4'd0);
		blank2 = blank1 && (t_w == 4'd0);
		if (func_s3) begin
			seg0_w = SEG_E;
			seg1_w = SEG_E;
			seg2_w = SEG_R;
			seg3_w = cblank_s3 ? SEG_BLANK : seg_of(cdig_s3);
		end else begin
			seg0_w = blank0 ? SEG_BLANK : seg_of(d0_s3);
			seg1_w = (blank1 ? SEG_BLANK : seg_of(d1_s3)) | (colon_s3 ? SEG_COLON : SEG_BLANK);
			seg2_w = blank2 ? SEG_BLANK : seg_of(t_w);
			seg3_w = seg_of(u_w[3:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			dig0_s4 <= seg0_w;
			dig1_s4 <= seg1_w;
			dig2_s4 <= seg2_w;
			dig3_s4 <= seg3_w;
		end
	end

	// Select the current word and its framing marks
	assign out_valid = valid_s4;
	assign last_byte = (word_idx_q == WORD_ON_CMD);

	always_comb begin
		data_byte   = SEG_BLANK;
		frame_start = 1'b0;
		frame_stop  = 1'b0;
		unique case (word_idx_q)
			WORD_DATA_CMD: begin
				data_byte   = CMD_DATA;
				frame_start = 1'b1;
				frame_stop  = 1'b1;
			end
			WORD_ADDR_CMD: begin
				data_byte   = CMD_ADDR;
				frame_start = 1'b1;
			end
			WORD_DIGIT0: data_byte = dig0_s4;
			WORD_DIGIT1: data_byte = dig1_s4;
			WORD_DIGIT2: data_byte = dig2_s4;
			WORD_DIGIT3: begin
				data_byte  = dig3_s4;
				frame_stop = 1'b1;
			end
			WORD_ON_CMD: begin
				data_byte   = CMD_ON + {5'd0, brightness_q};
				frame_start = 1'b1;
				frame_stop  = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/ssfb_checker.sv */
// Port-level checker for the seven-segment frame builder, bound to the top.
// Depends on ssfb_pkg and seven_segment_frame_builder_assert.svh.
`include "seven_segment_frame_builder_assert.svh"

module ssfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] data_byte,
	input logic       frame_start,
	input logic       frame_stop,
	input logic       last_byte
);
	import ssfb_pkg::*;

	// Hold a stalled word
	`SSFB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(last_byte), "stalled output word changed")

	// The final word is the display-on command in its own frame
	`SSFB_ASSERT_NOW(a_last_is_on, out_valid && last_byte, frame_start && frame_stop && (data_byte[7:3] == CMD_ON[7:3]), "final word is not a framed display-on command")

	// A word framed alone that is not final is the data command
	`SSFB_ASSERT_NOW(a_data_cmd, out_valid && frame_start && frame_stop && !last_byte, data_byte == CMD_DATA, "lone framed word is not the data command")

	// A frame that opens and stays open starts with the address command
	`SSFB_ASSERT_NOW(a_addr_cmd, out_valid && frame_start && !frame_stop, (data_byte == CMD_ADDR) && !last_byte, "open frame does not start with the address command")

endmodule

bind seven_segment_frame_builder ssfb_checker u_ssfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.data_byte   (data_byte),
	.frame_start (frame_start),
	.frame_stop  (frame_stop),
	.last_byte   (last_byte)
);
